>>> rtl/core/mtr_pkg.sv
// Shared types, constants and constant tables of the top-2 expert router.
`default_nettype none

package mtr_pkg;

  localparam int EXPERT_W    = 4;   // width of an expert index on the result
  localparam int LOGIT_W     = 16;  // signed Q8.8 logit
  localparam int WEIGHT_W    = 16;  // unsigned Q1.15 weight
  localparam int DIFF_W      = 16;  // logit difference, Q8.8, never negative
  localparam int EXP_STEPS   = 12;  // difference bits that feed the exponent
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

  // One finished row handed from the front to the back.
  typedef struct packed {
    logic [EXPERT_W-1:0] first_expert;
    logic [EXPERT_W-1:0] second_expert;
    logic [DIFF_W-1:0]   diff;
  } mtr_row_t;

  // exp(-1/256) in Q0.32 from a Q2.62 Taylor series, rounded half up.
  // Term n is term n-1 divided by 256*n.
  localparam logic [63:0] TAYLOR_ONE = 64'd1 << 62;
  localparam logic [63:0] TAYLOR_T1  = TAYLOR_ONE / 64'd256;
  localparam logic [63:0] TAYLOR_T2  = TAYLOR_T1 / 64'd512;
  localparam logic [63:0] TAYLOR_T3  = TAYLOR_T2 / 64'd768;
  localparam logic [63:0] TAYLOR_T4  = TAYLOR_T3 / 64'd1024;
  localparam logic [63:0] TAYLOR_T5  = TAYLOR_T4 / 64'd1280;
  localparam logic [63:0] TAYLOR_T6  = TAYLOR_T5 / 64'd1536;
  localparam logic [63:0] TAYLOR_T7  = TAYLOR_T6 / 64'd1792;
  localparam logic [63:0] TAYLOR_T8  = TAYLOR_T7 / 64'd2048;
  localparam logic [63:0] TAYLOR_T9  = TAYLOR_T8 / 64'd2304;
  localparam logic [63:0] TAYLOR_T10 = TAYLOR_T9 / 64'd2560;
  localparam logic [63:0] TAYLOR_T11 = TAYLOR_T10 / 64'd2816;
  localparam logic [63:0] TAYLOR_T12 = TAYLOR_T11 / 64'd3072;
  localparam logic [63:0] TAYLOR_T13 = TAYLOR_T12 / 64'd3328;
  localparam logic [63:0] TAYLOR_T14 = TAYLOR_T13 / 64'd3584;
  localparam logic [63:0] TAYLOR_T15 = TAYLOR_T14 / 64'd3840;
  localparam logic [63:0] TAYLOR_SUM = TAYLOR_ONE
      - TAYLOR_T1 + TAYLOR_T2 - TAYLOR_T3 + TAYLOR_T4 - TAYLOR_T5
      + TAYLOR_T6 - TAYLOR_T7 + TAYLOR_T8 - TAYLOR_T9 + TAYLOR_T10
      - TAYLOR_T11 + TAYLOR_T12 - TAYLOR_T13 + TAYLOR_T14 - TAYLOR_T15;
  localparam logic [31:0] EXP_BASE_Q32 = 32'((TAYLOR_SUM + (64'd1 << 29)) >> 30);

  // exp(-2^k/256) in Q0.32 by repeated rounded squaring of the base.
  function automatic logic [31:0] exp_factor(input int k);
    logic [31:0] f;
    logic [64:0] p;
    f = EXP_BASE_Q32;
    for (int i = 0; i < k; i++) begin
      p = 65'(f) * 65'(f) + (65'd1 << 31);
      f = 32'(p >> 32);
    end
    return f;
  endfunction

  localparam logic [EXP_STEPS-1:0][31:0] EXP_FACTORS = {
    exp_factor(11), exp_factor(10), exp_factor(9), exp_factor(8),
    exp_factor(7),  exp_factor(6),  exp_factor(5), exp_factor(4),
    exp_factor(3),  exp_factor(2),  exp_factor(1), exp_factor(0)
  };

endpackage

`default_nettype wire

>>> rtl/core/mtr_front.sv
// Front end: tracks the top two logits of a row and queues each finished row.
`default_nettype none

module mtr_front #(
  parameter int MAX_EXPERTS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [4:0]                  num_experts,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mtr_pkg::LOGIT_W-1:0] logit,
  input  wire logic                        queue_full,
  output logic                             push,
  output mtr_pkg::mtr_row_t                push_data
);
  import mtr_pkg::*;

  localparam int IDX_W   = $clog2(MAX_EXPERTS);
  localparam int CLOG_N  = $clog2(MAX_EXPERTS + 1);
  localparam int LEN_W   = (CLOG_N > 5) ? CLOG_N : 5;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_EXPERTS);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

  logic [IDX_W-1:0]          position;
  logic signed [LOGIT_W-1:0] best_value;
  logic [IDX_W-1:0]          best_index;
  logic signed [LOGIT_W-1:0] runner_value;
  logic [IDX_W-1:0]          runner_index;
  logic                      runner_found;

  logic signed [LOGIT_W-1:0] best_value_next;
  logic [IDX_W-1:0]          best_index_next;
  logic signed [LOGIT_W-1:0] runner_value_next;
  logic [IDX_W-1:0]          runner_index_next;
  logic                      runner_found_next;

  logic [LEN_W-1:0]          cfg_len;
  logic [LEN_W-1:0]          row_len;
  logic                      row_end;
  logic                      accept;
  logic signed [LOGIT_W:0]   diff_wide;

  always_comb begin
    cfg_len = LEN_W'(num_experts);
    if (cfg_len < LEN_MIN) begin
      row_len = LEN_MIN;
    end else if (cfg_len > LEN_MAX) begin
      row_len = LEN_MAX;
    end else begin
      row_len = cfg_len;
    end
  end

  assign row_end  = (LEN_W'(position) + LEN_W'(1)) >= row_len;
  // only the row-ending item needs room in the queue
  assign in_ready = !row_end || !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    best_value_next   = best_value;
    best_index_next   = best_index;
    runner_value_next = runner_value;
    runner_index_next = runner_index;
    runner_found_next = runner_found;
    if (position == '0) begin
      best_value_next   = logit;
      best_index_next   = '0;
      runner_value_next = '0;
      runner_index_next = '0;
      runner_found_next = 1'b0;
    end else if ($signed(logit) > best_value) begin
      runner_value_next = best_value;
      runner_index_next = best_index;
      runner_found_next = 1'b1;
      best_value_next   = logit;
      best_index_next   = position;
    end else if (!runner_found || $signed(logit) > runner_value) begin
      runner_value_next = logit;
      runner_index_next = position;
      runner_found_next = 1'b1;
    end
  end

  assign diff_wide = {best_value_next[LOGIT_W-1], best_value_next}
                   - {runner_value_next[LOGIT_W-1], runner_value_next};

  assign push                    = accept && row_end;
  assign push_data.first_expert  = EXPERT_W'(best_index_next);
  assign push_data.second_expert = EXPERT_W'(runner_index_next);
  assign push_data.diff          = DIFF_W'(diff_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      best_value   <= '0;
      best_index   <= '0;
      runner_value <= '0;
      runner_index <= '0;
      runner_found <= 1'b0;
    end else if (accept) begin
      best_value   <= best_value_next;
      best_index   <= best_index_next;
      runner_value <= runner_value_next;
      runner_index <= runner_index_next;
      runner_found <= runner_found_next;
      position     <= row_end ? '0 : position + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mtr_queue.sv
// Short row queue between the front end and the weight unit.
`default_nettype none

module mtr_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  mtr_pkg::mtr_row_t push_data,
  output logic              full,
  output logic              pop_valid,
  input  wire logic         pop,
  output mtr_pkg::mtr_row_t pop_data
);
  import mtr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mtr_row_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mtr_back.sv
// Weight unit: sequential exponent and bit-serial divide, plus the result register.
`default_nettype none

module mtr_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         row_valid,
  input  mtr_pkg::mtr_row_t row,
  output logic              pop,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [39:0]       m_axis_tdata
);
  import mtr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam logic [3:0]  LAST_STEP = 4'(EXP_STEPS - 1);
  localparam logic [32:0] E_ONE     = 33'd1 << 32;

  state_t                state;
  logic [3:0]            step;
  logic [DIFF_W-1:0]     diff;
  logic [EXPERT_W-1:0]   first_expert;
  logic [EXPERT_W-1:0]   second_expert;
  logic [32:0]           e;      // Q1.32, exactly 1.0 until the first factor
  logic [63:0]           prod;
  logic [48:0]           rem;
  logic [48:0]           dsh;
  logic [WEIGHT_W-1:0]   quot;
  logic [3:0]            div_cnt;

  logic [EXPERT_W-1:0]   out_first_expert;
  logic [WEIGHT_W-1:0]   out_first_weight;
  logic [EXPERT_W-1:0]   out_second_expert;
  logic [WEIGHT_W-1:0]   out_second_weight;

  logic [31:0]           f_sel;
  logic [64:0]           prod_rnd;
  logic [33:0]           den;
  logic                  geq;
  logic                  out_free;

  assign f_sel    = EXP_FACTORS[step];
  assign prod_rnd = {1'b0, prod} + (65'd1 << 31);
  assign den      = {1'b0, e} + (34'd1 << 32);
  assign geq      = rem >= dsh;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign pop      = (state == ST_IDLE) && row_valid;

  assign m_axis_tdata = {out_second_weight, out_second_expert,
                         out_first_weight, out_first_expert};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      div_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in ST_DONE the load below decides tvalid
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (row_valid) begin
            diff          <= row.diff;
            first_expert  <= row.first_expert;
            second_expert <= row.second_expert;
            e             <= E_ONE;
            step          <= '0;
            if (row.diff[DIFF_W-1:EXP_STEPS] != '0) begin
              // exp term below one LSB: all weight on the first expert
              quot  <= WEIGHT_ONE;
              state <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (diff[step] && !e[32]) begin
            prod  <= 64'(e[31:0]) * 64'(f_sel);
            state <= ST_ACC;
          end else begin
            // 1.0 times a factor is the factor itself
            if (diff[step]) begin
              e <= {1'b0, f_sel};
            end
            if (step == LAST_STEP) begin
              state <= ST_PREP;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        ST_ACC: begin
          e <= 33'(prod_rnd >> 32);
          if (step == LAST_STEP) begin
            state <= ST_PREP;
          end else begin
            step  <= step + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_PREP: begin
          rem     <= (49'd1 << 47) + 49'(den >> 1);
          dsh     <= 49'(den) << 15;
          quot    <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (geq) begin
            rem <= rem - dsh;
          end
          quot    <= {quot[WEIGHT_W-2:0], geq};
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(WEIGHT_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_first_expert  <= first_expert;
            out_first_weight  <= quot;
            out_second_expert <= second_expert;
            out_second_weight <= WEIGHT_ONE - quot;
            m_axis_tvalid     <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/moe_top2_expert_router.sv
// Top level of the top-2 mixture-of-experts router.
// Usage:
//  - s_axis carries one gate logit per transaction (signed Q8.8), experts of a
//    token in index order; a row is num_experts transactions (clamped to
//    2..MAX_EXPERTS). No tlast: the row length comes from the register.
//  - cfg_wr_en/cfg_wr_data write num_experts (reset 16); write only while idle.
//  - m_axis carries one transaction per row: both expert indices and their
//    renormalized Q1.15 weights (second weight = 32768 - first weight).
// Throughput: the front takes one logit per cycle; only a row-ending logit
// waits for room in the two-row queue. The weight unit handles one row at a
// time: a saturated logit gap goes straight to the result, else 12 exponent
// steps (each set gap bit after the first uses the shared 32x32 multiplier),
// then a restoring divide for the 16-bit weight.
// Reset clears the row tracker, the queue and the result valid.
// A stalled m_axis holds the result; the queue then fills and the front holds
// off only the next row-ending logit.
`default_nettype none

module moe_top2_expert_router #(
  parameter int MAX_EXPERTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,    // num_experts
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] logit
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [3:0] first_expert, [19:4] first_weight,
                                           // [23:20] second_expert, [39:24] second_weight
);
  import mtr_pkg::*;

  logic [4:0] num_experts;
  logic       queue_full;
  logic       push;
  mtr_row_t   push_data;
  logic       row_valid;
  logic       pop;
  mtr_row_t   row;

  // row length register; a mid-row write keeps the partial row
  always_ff @(posedge clk) begin
    if (rst) begin
      num_experts <= 5'd16;
    end else if (cfg_wr_en) begin
      num_experts <= cfg_wr_data;
    end
  end

  mtr_front #(
    .MAX_EXPERTS(MAX_EXPERTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .num_experts(num_experts),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .logit      (s_axis_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  mtr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop_valid(row_valid),
    .pop      (pop),
    .pop_data (row)
  );

  mtr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .row_valid    (row_valid),
    .row          (row),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> tb/moe_top2_expert_router_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the top-2 expert router: logit rows in, checked routes out.
module moe_top2_expert_router_tb;
  import mtr_pkg::*;

  localparam int MAX_EXPERTS   = 16;
  localparam int SAT_GAP       = 4096;    // logit gap from which the lead weight is 1.0
  localparam int SETTLE_CYCLES = 64;      // above the worst row-end to result latency
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_LOGITS = 990;

  // Same bit order as m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [WEIGHT_W-1:0] second_weight;
    logic [EXPERT_W-1:0] second_expert;
    logic [WEIGHT_W-1:0] first_weight;
    logic [EXPERT_W-1:0] first_expert;
  } route_t;

  // Content of a logit row.
  typedef enum int {
    ROW_CLOSE,   // logits spread over 3000 LSBs: mostly the exponent path
    ROW_FEW,     // values from a tiny set: lots of ties
    ROW_SPREAD,  // full 16-bit range: mostly saturated gaps
    ROW_EDGE,    // extremes and values around zero
    ROW_FLAT     // every logit equal
  } row_style_t;

  // Back-pressure patterns of the result side.
  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_pattern_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [4:0]          cfg_wr_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [LOGIT_W-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;

  // Predicted router state and register copy
  logic [4:0]          row_len_cfg = 5'd16;
  int                  row_pos = 0;
  logic signed [15:0]  lead_val = '0;
  logic [3:0]          lead_idx = '0;
  logic signed [15:0]  trail_val = '0;
  logic [3:0]          trail_idx = '0;
  logic                trail_seen = 1'b0;

  route_t              expected_routes[$];
  int                  mismatches = 0;
  int                  routes_checked = 0;
  int                  routes_predicted = 0;
  int                  logits_sent = 0;
  int                  cfg_writes = 0;
  int                  burst_left = 0;
  int                  cycle_count = 0;

  ready_pattern_t      ready_mode = READY_ALWAYS;
  int                  ready_left = 0;

  always #1 clk = ~clk;

  moe_top2_expert_router #(
    .MAX_EXPERTS(MAX_EXPERTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),      // [15:0] logit
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)       // [3:0] first_expert, [19:4] first_weight,
                                      // [23:20] second_expert, [39:24] second_weight
  );

  // ---------------------------------------------------------------------------
  // Weight arithmetic: Q0.32 exponent of the gap, then a rounded Q1.15 divide.
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
    return 64'((128'(a) * 128'(b) + (128'd1 << 31)) >> 32);
  endfunction

  // Weight of the larger logit for the gap (Q8.8, never negative).
  function automatic logic [15:0] lead_weight(input logic [15:0] gap);
    logic [63:0] series;
    logic [63:0] term;
    logic [63:0] fac;
    logic [63:0] acc;
    logic [63:0] den;
    if (gap >= SAT_GAP) return WEIGHT_ONE;
    // exp(-1/256) by Taylor series in Q2.62, rounded half up to Q0.32
    series = 64'd1 << 62;
    term   = 64'd1 << 62;
    for (int n = 1; n < 16; n++) begin
      term   = term / (64'd256 * 64'(n));
      series = (n % 2 != 0) ? series - term : series + term;
    end
    fac = (series + (64'd1 << 29)) >> 30;
    // multiply in exp(-2^k/256) for each set bit of the gap
    acc = 64'd1 << 32;
    for (int k = 0; k < 12; k++) begin
      if (gap[k]) acc = q32_mul(acc, fac);
      fac = q32_mul(fac, fac);
    end
    den = (64'd1 << 32) + acc;
    return 16'(((64'd1 << 47) + den / 2) / den);
  endfunction

  // Row length actually used for a register value.
  function automatic int row_span(input logic [4:0] n);
    if (n < 2) return 2;
    if (n > MAX_EXPERTS) return MAX_EXPERTS;
    return int'(n);
  endfunction

  // Advance the predicted tracker by one accepted logit; queue a route at row end.
  task automatic route_logit(input logic [15:0] raw);
    logic signed [15:0] v;
    logic [15:0]        gap;
    route_t             r;
    v = raw;
    if (row_pos == 0) begin
      lead_val   = v;
      lead_idx   = '0;
      trail_seen = 1'b0;
      trail_val  = '0;
      trail_idx  = '0;
    end else if (v > lead_val) begin
      // old leader drops to runner-up
      trail_val  = lead_val;
      trail_idx  = lead_idx;
      trail_seen = 1'b1;
      lead_val   = v;
      lead_idx   = 4'(row_pos);
    end else if (!trail_seen || v > trail_val) begin
      // an equal-to-leader logit can still take runner-up
      trail_val  = v;
      trail_idx  = 4'(row_pos);
      trail_seen = 1'b1;
    end
    logits_sent++;
    // a register shortened mid-row to no more than the logits taken so far ends the row on the next logit
    if (row_pos + 1 < row_span(row_len_cfg)) begin
      row_pos++;
    end else begin
      row_pos = 0;
      gap = 16'(int'(lead_val) - int'(trail_val));
      r.first_expert  = lead_idx;
      r.first_weight  = lead_weight(gap);
      r.second_expert = trail_idx;
      r.second_weight = WEIGHT_ONE - r.first_weight;
      expected_routes.push_back(r);
      routes_predicted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Sends one logit; the sender runs in bursts with random gaps between them.
  // tvalid is only dropped when a gap starts, so it never gets two updates per step.
  task automatic send_logit(input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    route_logit(v);
  endtask

  function automatic row_style_t pick_style();
    int p;
    p = $urandom_range(0, 19);
    if (p < 9)  return ROW_CLOSE;
    if (p < 13) return ROW_FEW;
    if (p < 16) return ROW_SPREAD;
    if (p < 18) return ROW_EDGE;
    return ROW_FLAT;
  endfunction

  task automatic send_row(input int count, input row_style_t style);
    logic [15:0] base;
    logic [15:0] v;
    base = 16'($urandom_range(0, 65535));
    for (int i = 0; i < count; i++) begin
      case (style)
        ROW_CLOSE:  v = base + 16'($urandom_range(0, 3000)) - 16'd1500;
        ROW_FEW:    v = base + 16'($urandom_range(0, 2));
        ROW_SPREAD: v = 16'($urandom_range(0, 65535));
        ROW_EDGE: begin
          case ($urandom_range(0, 4))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'h0000;
            3:       v = 16'hFFFF;
            default: v = 16'h0001;
          endcase
        end
        default:    v = base;
      endcase
      send_logit(v);
    end
  endtask

  // Idle the sender and wait until every predicted route has come out, then
  // give a partial row in flight time to settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only once every predicted route has come out.
  task automatic write_row_length(input logic [4:0] n);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    row_len_cfg = n;
    cfg_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset row length of 16 with both logit extremes and a tie at the top,
  // then two-expert rows: widest unsaturated gap, negative tie, first saturated gap.
  task automatic test_directed_rows();
    logic [15:0] full_row [16];
    logic [15:0] pairs [6];
    full_row = '{16'h8000, 16'h0100, 16'hFF00, 16'h0000, 16'h7F00, 16'h8001, 16'h0005,
                 16'hFFFF, 16'h1234, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFE, 16'h4000,
                 16'h7FFF, 16'hC000};
    pairs = '{16'h07FF, 16'hF800, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h1000};
    foreach (full_row[i]) send_logit(full_row[i]);
    write_row_length(5'd2);
    foreach (pairs[i]) send_logit(pairs[i]);
  endtask

  // Register shortened while a row is partly done: the next logit closes the row.
  task automatic test_row_length_change_midrow();
    write_row_length(5'd16);
    send_row(5, ROW_CLOSE);
    write_row_length(5'd3);
    send_row(1, ROW_FEW);
    send_row(3, ROW_CLOSE);
  endtask

  // Phases of random rows over many register settings, including the clamped
  // ones; some phases leave a partial row behind for the next setting.
  task automatic test_random_rows();
    logic [4:0] setting;
    int         len;
    int         rows;
    int         stop_at;
    stop_at = logits_sent + RANDOM_LOGITS;
    while (logits_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       setting = 5'd2;
        1:       setting = 5'd16;
        2:       setting = 5'd0;
        3:       setting = 5'd1;
        4:       setting = 5'd31;
        5:       setting = 5'd17;
        default: setting = 5'($urandom_range(0, 31));
      endcase
      write_row_length(setting);
      len  = row_span(setting);
      rows = 1 + $urandom_range(0, 120 / len);
      repeat (rows) send_row(len, pick_style());
      if ($urandom_range(0, 3) == 0) send_row($urandom_range(1, len - 1), pick_style());
    end
  endtask

  task automatic finish_run();
    drain_results();
    $display("%0d logits in %0d rows over %0d register writes, %0d routes checked",
             logits_sent, routes_predicted, cfg_writes, routes_checked);
    if (mismatches == 0 && expected_routes.size() == 0) begin
      $display("moe_top2_expert_router verification clean");
    end else begin
      $display("moe_top2_expert_router verification failed");
    end
    $finish;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_rows();
    test_row_length_change_midrow();
    test_random_rows();
    finish_run();
  end

  // ---------------------------------------------------------------------------
  // Result side: back-pressure and checking
  // ---------------------------------------------------------------------------

  // Result-side stall pattern, switched at random intervals.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_pattern_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: m_axis_tready <= 1'b1;
      READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:      m_axis_tready <= ((cycle_count % 24) >= 16);
    endcase
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every accepted route transaction is compared with the oldest prediction.
  always @(posedge clk) begin : route_check
    route_t got;
    route_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_routes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected route transaction, expected none, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = expected_routes.pop_front();
        check_field("first_expert", want.first_expert, got.first_expert);
        check_field("first_weight", want.first_weight, got.first_weight);
        check_field("second_expert", want.second_expert, got.second_expert);
        check_field("second_weight", want.second_weight, got.second_weight);
      end
      routes_checked++;
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d routes outstanding",
               cycle_count, expected_routes.size());
      $display("moe_top2_expert_router verification failed");
      $finish;
    end
  end

endmodule

>>> moe_top2_expert_router.f
rtl/core/mtr_pkg.sv
rtl/core/mtr_front.sv
rtl/core/mtr_queue.sv
rtl/core/mtr_back.sv
rtl/core/moe_top2_expert_router.sv
tb/moe_top2_expert_router_tb.sv
